// ----- src/bmp_pkg.sv -----
`timescale 1ns / 1ps

package bmp_pkg;

    localparam int MAX_BITS   = 256;
    localparam int SIZE_W     = 9;
    localparam int INDEX_W    = 8;
    localparam int ACTION_W   = 4;
    localparam int POS_W      = 8;
    localparam int COUNT_W    = 9;
    localparam int SIZE_RESET = 256;

    // one cell holds a slice of the bitmap
    localparam int SLICE_W     = (MAX_BITS < 32) ? MAX_BITS : 32;
    localparam int SLICE_IDX_W = $clog2(SLICE_W);
    localparam int NUM_CELLS   = MAX_BITS / SLICE_W;
    localparam int CELL_IDX_W  = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

    // width that holds any bit index, the size register and MAX_BITS itself
    localparam int CMP_W = (SIZE_W > $clog2(MAX_BITS) + 1) ? SIZE_W : $clog2(MAX_BITS) + 1;
    localparam int CNT_W = $clog2(MAX_BITS + 1);

    typedef enum logic [ACTION_W-1:0] {
        ACT_SET        = 4'd0,
        ACT_CLEAR      = 4'd1,
        ACT_TOGGLE     = 4'd2,
        ACT_READ       = 4'd3,
        ACT_SET_ALL    = 4'd4,
        ACT_CLEAR_ALL  = 4'd5,
        ACT_INVERT     = 4'd6,
        ACT_NEXT_SET   = 4'd7,
        ACT_NEXT_CLEAR = 4'd8
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [INDEX_W-1:0]  index;
    } in_item_t;

    typedef struct packed {
        logic               status;
        logic               bit_value;
        logic               found;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] set_count;
        logic               any_set;
        logic               all_set;
    } out_item_t;

    // command broadcast to every cell
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [CMP_W-1:0]    idx;
        logic [CMP_W-1:0]    n;
        logic                in_range;
    } cell_cmd_t;

    // scan token handed from cell to cell
    typedef struct packed {
        logic             valid;
        logic             bitv;
        logic             found;
        logic [POS_W-1:0] pos;
        logic [CNT_W-1:0] count;
    } token_t;

endpackage

// ----- src/bmp_cell.sv -----
`timescale 1ns / 1ps

module bmp_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [bmp_pkg::CELL_IDX_W-1:0]      cell_id,
    input  logic                                apply,
    input  bmp_pkg::cell_cmd_t                  cmd,
    input  bmp_pkg::token_t                     tok_in,
    output bmp_pkg::token_t                     tok_out
);

    logic [bmp_pkg::SLICE_W-1:0]     slice_reg;
    logic [bmp_pkg::SLICE_W-1:0]     slice_next;
    bmp_pkg::token_t                 tok_reg;
    bmp_pkg::token_t                 tok_next;

    logic [bmp_pkg::CMP_W-1:0]       base;
    logic [bmp_pkg::CMP_W-1:0]       gbit;
    logic [bmp_pkg::SLICE_W-1:0]     below;
    logic [bmp_pkg::SLICE_W-1:0]     from_start;
    logic [bmp_pkg::SLICE_W-1:0]     hit;
    logic [bmp_pkg::SLICE_IDX_W-1:0] hit_off;
    logic [bmp_pkg::SLICE_IDX_W-1:0] boff;
    logic                            sel;
    logic                            find_en;
    logic                            want;
    logic                            read_en;

    always_comb
    begin
        base = bmp_pkg::CMP_W'(cell_id) << bmp_pkg::SLICE_IDX_W;
        gbit = '0;
        for (int k = 0; k < bmp_pkg::SLICE_W; k++)
        begin
            gbit          = base + bmp_pkg::CMP_W'(k);
            below[k]      = gbit < cmd.n;
            from_start[k] = gbit >= cmd.idx;
        end
        sel  = (cmd.idx >> bmp_pkg::SLICE_IDX_W) == bmp_pkg::CMP_W'(cell_id);
        boff = cmd.idx[bmp_pkg::SLICE_IDX_W-1:0];
    end

    // state change, applied on the transfer edge
    always_comb
    begin
        slice_next = slice_reg;
        if (apply)
        begin
            unique case (cmd.action)
                bmp_pkg::ACT_SET:
                    if (cmd.in_range && sel) slice_next[boff] = 1'b1;
                bmp_pkg::ACT_CLEAR:
                    if (cmd.in_range && sel) slice_next[boff] = 1'b0;
                bmp_pkg::ACT_TOGGLE:
                    if (cmd.in_range && sel) slice_next[boff] = ~slice_reg[boff];
                bmp_pkg::ACT_SET_ALL:   slice_next = slice_reg | below;
                bmp_pkg::ACT_CLEAR_ALL: slice_next = '0;
                bmp_pkg::ACT_INVERT:    slice_next = slice_reg ^ below;
                default:                slice_next = slice_reg;
            endcase
        end
    end

    // scan step: count, find and read on this slice
    always_comb
    begin
        find_en = cmd.in_range && ((cmd.action == bmp_pkg::ACT_NEXT_SET) ||
                                   (cmd.action == bmp_pkg::ACT_NEXT_CLEAR));
        want    = cmd.action == bmp_pkg::ACT_NEXT_SET;
        read_en = cmd.in_range && (cmd.action == bmp_pkg::ACT_READ) && sel;
        hit     = (want ? slice_reg : ~slice_reg) & below & from_start;

        hit_off = '0;
        for (int k = bmp_pkg::SLICE_W - 1; k >= 0; k--)
        begin
            if (hit[k]) hit_off = bmp_pkg::SLICE_IDX_W'(k);
        end

        tok_next       = tok_in;
        tok_next.count = tok_in.count
                       + bmp_pkg::CNT_W'($countones(slice_reg & below));
        if (find_en && (|hit) && !tok_in.found)
        begin
            tok_next.found = 1'b1;
            tok_next.pos   = bmp_pkg::POS_W'(base + bmp_pkg::CMP_W'(hit_off));
        end
        if (read_en)
        begin
            tok_next.bitv = tok_in.bitv | slice_reg[boff];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_reg <= '0;
            tok_reg   <= '0;
        end
        else
        begin
            slice_reg <= slice_next;
            tok_reg   <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ----- src/bitmap_engine_with_count_and_find.sv -----
`timescale 1ns / 1ps
// a scan token walks the row of 8 cells, one 32-bit slice per cycle,
//   to gather count, find and read results
// in_stall is high from the transfer until the result is loaded into the output register
// reset: asynchronous, active low; clears the bitmap and sets the size register to 256
module bitmap_engine_with_count_and_find (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  bmp_pkg::in_item_t           in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output bmp_pkg::out_item_t          out_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [bmp_pkg::SIZE_W-1:0]  cfg_data
);

    bmp_pkg::state_t            state_reg;
    bmp_pkg::state_t            state_next;
    logic [bmp_pkg::SIZE_W-1:0] size_reg;
    bmp_pkg::cell_cmd_t         cmd_reg;
    bmp_pkg::cell_cmd_t         new_cmd;
    bmp_pkg::cell_cmd_t         cell_cmd;
    logic                       start_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    bmp_pkg::out_item_t         out_data_reg;
    bmp_pkg::out_item_t         out_data_next;
    bmp_pkg::out_item_t         res_reg;
    bmp_pkg::out_item_t         res_next;
    bmp_pkg::out_item_t         scan_res;
    logic [bmp_pkg::CMP_W-1:0]  n_eff;
    logic                       accept;
    logic                       out_free;
    logic                       oor;
    bmp_pkg::token_t            chain [bmp_pkg::NUM_CELLS+1];

    assign cfg_ready = 1'b1;
    assign in_stall  = state_reg != bmp_pkg::ST_IDLE;
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        n_eff = (bmp_pkg::CMP_W'(size_reg) > bmp_pkg::CMP_W'(bmp_pkg::MAX_BITS))
              ? bmp_pkg::CMP_W'(bmp_pkg::MAX_BITS) : bmp_pkg::CMP_W'(size_reg);
        new_cmd.action   = in_data.action;
        new_cmd.idx      = bmp_pkg::CMP_W'(in_data.index);
        new_cmd.n        = n_eff;
        new_cmd.in_range = bmp_pkg::CMP_W'(in_data.index) < n_eff;
        cell_cmd         = accept ? new_cmd : cmd_reg;
    end

    always_comb
    begin
        chain[0]       = '0;
        chain[0].valid = start_reg;
    end

    for (genvar g = 0; g < bmp_pkg::NUM_CELLS; g++)
    begin : g_cell
        bmp_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cell_id (bmp_pkg::CELL_IDX_W'(g)),
            .apply   (accept),
            .cmd     (cell_cmd),
            .tok_in  (chain[g]),
            .tok_out (chain[g+1])
        );
    end

    // result from the token leaving the last cell
    always_comb
    begin
        unique case (cmd_reg.action)
            bmp_pkg::ACT_SET, bmp_pkg::ACT_CLEAR, bmp_pkg::ACT_TOGGLE, bmp_pkg::ACT_READ,
            bmp_pkg::ACT_NEXT_SET, bmp_pkg::ACT_NEXT_CLEAR:
                oor = !cmd_reg.in_range;
            default:
                oor = 1'b0;
        endcase
        scan_res.status    = oor;
        scan_res.bit_value = chain[bmp_pkg::NUM_CELLS].bitv;
        scan_res.found     = chain[bmp_pkg::NUM_CELLS].found;
        scan_res.position  = chain[bmp_pkg::NUM_CELLS].found
                           ? chain[bmp_pkg::NUM_CELLS].pos : '0;
        scan_res.set_count = bmp_pkg::COUNT_W'(chain[bmp_pkg::NUM_CELLS].count);
        scan_res.any_set   = chain[bmp_pkg::NUM_CELLS].count != '0;
        scan_res.all_set   = bmp_pkg::CMP_W'(chain[bmp_pkg::NUM_CELLS].count) == cmd_reg.n;
    end

    always_comb
    begin
        state_next     = state_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            bmp_pkg::ST_IDLE:
            begin
                if (accept) state_next = bmp_pkg::ST_SCAN;
            end
            bmp_pkg::ST_SCAN:
            begin
                if (chain[bmp_pkg::NUM_CELLS].valid)
                begin
                    if (out_free)
                    begin
                        out_data_next  = scan_res;
                        out_valid_next = 1'b1;
                        state_next     = bmp_pkg::ST_IDLE;
                    end
                    else
                    begin
                        res_next   = scan_res;
                        state_next = bmp_pkg::ST_HOLD;
                    end
                end
            end
            bmp_pkg::ST_HOLD:
            begin
                if (out_free)
                begin
                    out_data_next  = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = bmp_pkg::ST_IDLE;
                end
            end
            default:
                state_next = bmp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bmp_pkg::ST_IDLE;
            size_reg      <= bmp_pkg::SIZE_W'(bmp_pkg::SIZE_RESET);
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= accept;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) size_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) cmd_reg <= new_cmd;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- src/bmp_checker.sv -----
`timescale 1ns / 1ps

module bmp_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input bmp_pkg::out_item_t out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // one item at a time: busy right after a transfer
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while an item is in flight");

    a_any_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.any_set == (out_data.set_count != '0))
        else $error("any_set disagrees with set_count");

    a_oor_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status |->
            !out_data.found && !out_data.bit_value && (out_data.position == '0))
        else $error("out-of-range result carries find or read data");

    a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.found |-> out_data.position == '0)
        else $error("position set without a find");

endmodule

bind bitmap_engine_with_count_and_find bmp_checker u_bmp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ----- tb/bitmap_engine_with_count_and_find_test.sv -----
`timescale 1ns / 1ps

module bitmap_engine_with_count_and_find_test;

    import bmp_pkg::*;

    localparam int CLK_PERIOD    = 4;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 20;
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 50;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [ACTION_W-1:0] ACT_UNKNOWN_LO = 4'd9;
    localparam logic [ACTION_W-1:0] ACT_UNKNOWN_HI = 4'd15;
    localparam logic                STATUS_OK      = 1'b0;
    localparam logic                STATUS_RANGE   = 1'b1;

    class bitmap_scoreboard;
        logic [MAX_BITS-1:0] bit_image = '0;
        int unsigned         size_reg = SIZE_RESET;
        out_item_t           expected_responses[$];
        int unsigned         failures = 0;
        int unsigned         responses_checked = 0;
        int unsigned         range_errors = 0;
        int unsigned         find_hits = 0;
        int unsigned         size_writes = 0;

        function void set_size(logic [SIZE_W-1:0] value);
            size_reg = 32'(value);
            size_writes++;
        endfunction

        function int unsigned pending();
            return expected_responses.size();
        endfunction

        function string fmt(out_item_t r);
            return $sformatf("status=%0d bit=%0d found=%0d pos=%0d count=%0d any=%0d all=%0d",
                             r.status, r.bit_value, r.found, r.position, r.set_count,
                             r.any_set, r.all_set);
        endfunction

        // applies one request to the local bitmap image and builds its response
        function out_item_t predict_response(in_item_t req);
            out_item_t   rsp;
            int unsigned n;
            int unsigned cnt;
            int unsigned i;
            logic        want;
            rsp = '0;
            cnt = 0;
            n = (size_reg > MAX_BITS) ? MAX_BITS : size_reg;
            case (req.action)
                ACT_SET, ACT_CLEAR, ACT_TOGGLE, ACT_READ:
                begin
                    if (req.index >= n)
                        rsp.status = STATUS_RANGE;
                    else if (req.action == ACT_SET)
                        bit_image[req.index] = 1'b1;
                    else if (req.action == ACT_CLEAR)
                        bit_image[req.index] = 1'b0;
                    else if (req.action == ACT_TOGGLE)
                        bit_image[req.index] = ~bit_image[req.index];
                    else
                        rsp.bit_value = bit_image[req.index];
                end
                ACT_SET_ALL:
                begin
                    for (i = 0; i < n; i++)
                        bit_image[i] = 1'b1;
                end
                ACT_CLEAR_ALL:
                begin
                    // wipes padding above the size as well
                    bit_image = '0;
                end
                ACT_INVERT:
                begin
                    for (i = 0; i < n; i++)
                        bit_image[i] = ~bit_image[i];
                end
                ACT_NEXT_SET, ACT_NEXT_CLEAR:
                begin
                    if (req.index >= n)
                        rsp.status = STATUS_RANGE;
                    else
                    begin
                        want = (req.action == ACT_NEXT_SET);
                        for (i = 32'(req.index); i < n && !rsp.found; i++)
                        begin
                            if (bit_image[i] == want)
                            begin
                                rsp.found = 1'b1;
                                rsp.position = i[POS_W-1:0];
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
            for (i = 0; i < n; i++)
                cnt += 32'(bit_image[i]);
            rsp.set_count = cnt[COUNT_W-1:0];
            rsp.any_set = (cnt != 0);
            rsp.all_set = (cnt == n);
            return rsp;
        endfunction

        function void note_request(in_item_t req);
            out_item_t rsp;
            rsp = predict_response(req);
            if (rsp.status == STATUS_RANGE)
                range_errors++;
            if (rsp.found)
                find_hits++;
            expected_responses.push_back(rsp);
        endfunction

        function void check_response(out_item_t got);
            out_item_t exp;
            responses_checked++;
            if (expected_responses.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected response %0d: %s", responses_checked, fmt(got));
                return;
            end
            exp = expected_responses.pop_front();
            if (got.status !== exp.status || got.bit_value !== exp.bit_value ||
                got.found !== exp.found || got.position !== exp.position ||
                got.set_count !== exp.set_count || got.any_set !== exp.any_set ||
                got.all_set !== exp.all_set)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("mismatch on response %0d\n  expected %s\n  actual   %s",
                             responses_checked, fmt(exp), fmt(got));
            end
        endfunction

        function void close_out();
            if (expected_responses.size() != 0)
            begin
                failures++;
                $display("%0d responses never arrived", expected_responses.size());
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    in_item_t             in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [SIZE_W-1:0]    cfg_data = '0;

    bitmap_scoreboard sb = new;
    bit               steady = 1'b0;
    int unsigned      stall_left = 0;
    int unsigned      quiet_cycles = 0;
    int unsigned      requests_sent = 0;

    bitmap_engine_with_count_and_find u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_request(in_data);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_response(out_data);
        if (stall_left > 0)
            stall_left--;
        else if (!steady && $urandom_range(0, 99) < 25)
            stall_left = gap_len();
        out_stall <= (stall_left > 0);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", quiet_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_request(logic [ACTION_W-1:0] act, logic [INDEX_W-1:0] idx);
        int unsigned gap;
        gap = steady ? 0 : gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{action: act, index: idx};
        do @(posedge clk); while (in_stall);
        requests_sent++;
    endtask

    // wait for a clock edge first so the transfer just made is already on the scoreboard
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(logic [SIZE_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_size(value);
    endtask

    function automatic logic [ACTION_W-1:0] pick_action();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15)      return ACT_SET;
        else if (r < 27) return ACT_CLEAR;
        else if (r < 42) return ACT_TOGGLE;
        else if (r < 57) return ACT_READ;
        else if (r < 60) return ACT_SET_ALL;
        else if (r < 63) return ACT_CLEAR_ALL;
        else if (r < 67) return ACT_INVERT;
        else if (r < 80) return ACT_NEXT_SET;
        else if (r < 94) return ACT_NEXT_CLEAR;
        else             return ACTION_W'($urandom_range(ACT_UNKNOWN_LO, ACT_UNKNOWN_HI));
    endfunction

    // mostly in range for the current size, with edges and strays mixed in
    function automatic logic [INDEX_W-1:0] pick_index(int unsigned size_val);
        int unsigned r;
        int unsigned lim;
        r = $urandom_range(0, 99);
        lim = (size_val > MAX_BITS) ? MAX_BITS : size_val;
        if (r < 5)
            return '0;
        else if (r < 10)
            return '1;
        else if (r < 15 && lim > 0)
            return INDEX_W'(lim - 1);
        else if (r < 85 && lim > 0)
            return INDEX_W'($urandom_range(0, lim - 1));
        else
            return INDEX_W'($urandom_range(0, 255));
    endfunction

    initial
    begin
        logic [SIZE_W-1:0] phase_size[RANDOM_PHASES];
        int unsigned       p;
        int unsigned       k;

        phase_size = '{9'd256, 9'd37, 9'd1, 9'd511, 9'd0, 9'd255, 9'd8, 9'd0};
        phase_size[RANDOM_PHASES-1] = SIZE_W'($urandom_range(2, 254));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full size from reset: empty map, single bits at both ends, whole-map actions
        send_request(ACT_READ, 8'd0);
        send_request(ACT_NEXT_SET, 8'd0);
        send_request(ACT_NEXT_CLEAR, 8'd255);
        send_request(ACT_SET, 8'd0);
        send_request(ACT_SET, 8'd255);
        send_request(ACT_TOGGLE, 8'd128);
        send_request(ACT_READ, 8'd128);
        send_request(ACT_NEXT_SET, 8'd1);
        send_request(ACT_CLEAR, 8'd0);
        send_request(ACT_NEXT_CLEAR, 8'd0);
        send_request(ACT_SET_ALL, 8'd0);
        send_request(ACT_NEXT_CLEAR, 8'd0);
        send_request(ACT_CLEAR, 8'd77);
        send_request(ACT_INVERT, 8'd200);
        send_request(ACT_NEXT_SET, 8'd3);
        send_request(ACT_UNKNOWN_LO, 8'd0);
        send_request(ACT_UNKNOWN_HI, 8'd255);
        send_request(ACT_CLEAR_ALL, 8'd9);

        // zero size: every indexed request out of range, all_set still reported high
        write_size(9'd0);
        send_request(ACT_SET, 8'd3);
        send_request(ACT_NEXT_SET, 8'd0);
        send_request(ACT_SET_ALL, 8'd0);

        // small size leaves padding above it untouched, then it shows up again
        write_size(9'd8);
        send_request(ACT_INVERT, 8'd0);
        send_request(ACT_NEXT_CLEAR, 8'd7);
        send_request(ACT_SET, 8'd8);
        write_size(9'd256);
        send_request(ACT_READ, 8'd7);

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            write_size(phase_size[p]);
            steady = (p == 2 || p == 5);
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if (p == 3 && k == PHASE_ITEMS / 2)
                    wait_drained();
                send_request(pick_action(), pick_index(32'(phase_size[p])));
            end
        end

        steady = 1'b0;
        wait_drained();
        sb.close_out();

        $display("sent %0d requests across %0d size writes, %0d responses checked",
                 requests_sent, sb.size_writes, sb.responses_checked);
        $display("out-of-range requests %0d, finds that hit %0d, failures %0d",
                 sb.range_errors, sb.find_hits, sb.failures);
        if (sb.failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
